// File: rtl/core/lkx_pkg.sv
// ============================================================================
// lkx_pkg: shared types and constants of the LCG keystream XOR cipher
// Holds the arithmetic constants, the result status codes and the command
// and status bundles between the controller and the datapath.
// ============================================================================
package lkx_pkg;

    // Hash, mixer and generator constants.
    localparam logic [63:0] HASH_INIT = 64'd5381;
    localparam logic [63:0] LCG_MUL   = 64'd6364136223846793005;
    localparam logic [63:0] LCG_ADD   = 64'd1442695040888963407;
    localparam logic [63:0] MIX_K1    = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_K2    = 64'hc4ceb9fe1a85ec53;
    localparam int unsigned MIX_SHIFT = 33;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DATA_DONE = 2'd0,
        ST_KEY_BYTE  = 2'd1,
        ST_KEY_DONE  = 2'd2,
        ST_REJECT    = 2'd3
    } status_t;

    // Constant operand of the shared multiplier.
    typedef enum logic [1:0] {
        KSEL_LCG  = 2'd0,
        KSEL_MIX1 = 2'd1,
        KSEL_MIX2 = 2'd2
    } ksel_t;

    // Product accumulator operation.
    typedef enum logic [1:0] {
        ACC_HOLD   = 2'd0,
        ACC_LOAD   = 2'd1,
        ACC_ADD_HI = 2'd2
    } acc_op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    item_load;
        logic    hash_absorb;
        logic    hash_finish;
        logic    w_load_lcg;
        logic    w_load_mix;
        logic    mul_a_hi;
        logic    mul_b_hi;
        ksel_t   k_sel;
        acc_op_t acc_op;
        logic    key_commit;
        logic    data_commit;
        logic    res_load;
        status_t res_status;
        logic    out_load;
    } lkx_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic item_mode;
        logic item_last;
        logic key_ready;
    } lkx_stat_t;

endpackage

// File: rtl/core/lkx_if.sv
// ============================================================================
// lkx_if: transaction channels of the LCG keystream XOR cipher
// Input channel carries one byte with its mode and last marks; output
// channel carries the processed byte and its status.
// ============================================================================
interface lkx_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] byte_in;
    logic       last;

    modport source (output valid, output mode, output byte_in, output last, input ready);
    modport sink   (input valid, input mode, input byte_in, input last, output ready);
endinterface

interface lkx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic [1:0] status;

    modport source (output valid, output byte_out, output status, input ready);
    modport sink   (input valid, input byte_out, input status, output ready);
endinterface

// File: rtl/core/lcg_keystream_xor_cipher.sv
// One transaction is in work at a time: a new input is taken only once the
// previous result has been handed to the output register. The shared 32x32
// multiplier builds each 64-bit constant product from three partial products
// (one product for data, two for the key finish).
// Reset clears the hash to 5381, seed, generator state and key flag to zero.
// ============================================================================
// lcg_keystream_xor_cipher: byte stream cipher keyed by a hashed key
// Absorbs key bytes into a multiply-by-33 hash, finishes it with a 64-bit
// mixer into the seed, and XORs data bytes with a 64-bit LCG keystream.
// ============================================================================
module lcg_keystream_xor_cipher (
    input  logic   clk,
    input  logic   rst_n,
    lkx_in_if.sink    in_ch,
    lkx_out_if.source out_ch
);

    lkx_pkg::lkx_cmd_t  cmd;
    lkx_pkg::lkx_stat_t stat;

    // Sequencer.
    lkx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hash, generator and multiplier.
    lkx_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_mode    (in_ch.mode),
        .in_byte    (in_ch.byte_in),
        .in_last    (in_ch.last),
        .out_byte   (out_ch.byte_out),
        .out_status (out_ch.status)
    );

endmodule

// File: rtl/core/lkx_dp.sv
// ============================================================================
// lkx_dp: datapath of the LCG keystream XOR cipher
// Holds the key hash, seed, generator state and a shared 32x32 multiplier
// that builds each 64-bit constant product from three partial products.
// ============================================================================
module lkx_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  lkx_pkg::lkx_cmd_t  cmd,
    output lkx_pkg::lkx_stat_t stat,
    input  logic               in_mode,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    output logic [7:0]         out_byte,
    output logic [1:0]         out_status
);

    // Architectural state.
    logic [63:0] hash_reg,  hash_next;
    logic [63:0] seed_reg,  seed_next;
    logic [63:0] lcg_reg,   lcg_next;
    logic        key_ready_reg, key_ready_next;

    // Working registers.
    logic [63:0] w_reg,     w_next;
    logic [63:0] prod_reg,  prod_next;
    logic [63:0] acc_reg,   acc_next;
    logic        mode_reg;
    logic        last_reg;
    logic [7:0]  byte_reg;
    logic [7:0]  res_byte_reg;
    logic [1:0]  res_status_reg;
    logic [7:0]  out_byte_reg;
    logic [1:0]  out_status_reg;

    logic [63:0] hash_absorbed;
    logic [63:0] acc_mixed;
    logic [63:0] lcg_stepped;
    logic [63:0] k_val;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [7:0]  data_xored;

    // Hash absorb, output mixing steps and generator add.
    always_comb
    begin
        hash_absorbed = ((hash_reg << 5) + hash_reg) ^ {56'd0, byte_reg};
        acc_mixed     = acc_reg ^ (acc_reg >> lkx_pkg::MIX_SHIFT);
        lcg_stepped   = acc_reg + lkx_pkg::LCG_ADD;
        data_xored    = byte_reg ^ lcg_stepped[23:16];
    end

    // Shared multiplier operand selection.
    always_comb
    begin
        case (cmd.k_sel)
            lkx_pkg::KSEL_MIX1: k_val = lkx_pkg::MIX_K1;
            lkx_pkg::KSEL_MIX2: k_val = lkx_pkg::MIX_K2;
            default:            k_val = lkx_pkg::LCG_MUL;
        endcase
        mul_a     = cmd.mul_a_hi ? w_reg[63:32] : w_reg[31:0];
        mul_b     = cmd.mul_b_hi ? k_val[63:32] : k_val[31:0];
        prod_next = {32'd0, mul_a} * {32'd0, mul_b};
    end

    // Product accumulation modulo 2^64.
    always_comb
    begin
        case (cmd.acc_op)
            lkx_pkg::ACC_LOAD:   acc_next = prod_reg;
            lkx_pkg::ACC_ADD_HI: acc_next = {acc_reg[63:32] + prod_reg[31:0], acc_reg[31:0]};
            default:             acc_next = acc_reg;
        endcase
    end

    // Next values of the key, seed and generator state.
    always_comb
    begin
        hash_next      = hash_reg;
        seed_next      = seed_reg;
        lcg_next       = lcg_reg;
        key_ready_next = key_ready_reg;
        w_next         = w_reg;
        if (cmd.hash_finish)
        begin
            hash_next = lkx_pkg::HASH_INIT;
            w_next    = hash_absorbed ^ (hash_absorbed >> lkx_pkg::MIX_SHIFT);
        end
        else if (cmd.hash_absorb)
        begin
            hash_next = hash_absorbed;
        end
        if (cmd.w_load_lcg)
        begin
            w_next = lcg_reg;
        end
        if (cmd.w_load_mix)
        begin
            w_next = acc_mixed;
        end
        if (cmd.key_commit)
        begin
            seed_next      = acc_mixed;
            lcg_next       = acc_mixed;
            key_ready_next = 1'b1;
        end
        if (cmd.data_commit)
        begin
            lcg_next = last_reg ? seed_reg : lcg_stepped;
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= lkx_pkg::HASH_INIT;
            seed_reg      <= '0;
            lcg_reg       <= '0;
            key_ready_reg <= 1'b0;
        end
        else
        begin
            hash_reg      <= hash_next;
            seed_reg      <= seed_next;
            lcg_reg       <= lcg_next;
            key_ready_reg <= key_ready_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        w_reg    <= w_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (cmd.item_load)
        begin
            mode_reg <= in_mode;
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
        if (cmd.res_load)
        begin
            res_byte_reg   <= cmd.data_commit ? data_xored : 8'd0;
            res_status_reg <= cmd.res_status;
        end
        if (cmd.out_load)
        begin
            out_byte_reg   <= res_byte_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign stat.item_mode = mode_reg;
    assign stat.item_last = last_reg;
    assign stat.key_ready = key_ready_reg;
    assign out_byte       = out_byte_reg;
    assign out_status     = out_status_reg;

endmodule

// File: rtl/core/lkx_ctrl.sv
// ============================================================================
// lkx_ctrl: controller of the LCG keystream XOR cipher
// Sequences each transaction through decode and, for accepted data bytes and
// the last key byte, the constant multiplies and the commit step, then the output register.
// ============================================================================
module lkx_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  lkx_pkg::lkx_stat_t stat,
    output lkx_pkg::lkx_cmd_t  cmd
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_EXEC     = 10'b0000000010,
        S_MUL0     = 10'b0000000100,
        S_MUL1     = 10'b0000001000,
        S_MUL2     = 10'b0000010000,
        S_MUL3     = 10'b0000100000,
        S_MIX      = 10'b0001000000,
        S_FIN_KEY  = 10'b0010000000,
        S_FIN_DATA = 10'b0100000000,
        S_DONE     = 10'b1000000000
    } state_t;

    state_t              state_reg, state_next;
    lkx_pkg::ksel_t      ksel_reg,  ksel_next;
    logic                out_valid_reg, out_valid_next;

    // Next state and command decode.
    always_comb
    begin
        state_next     = state_reg;
        ksel_next      = ksel_reg;
        cmd            = '0;
        cmd.k_sel      = ksel_reg;
        cmd.acc_op     = lkx_pkg::ACC_HOLD;
        cmd.res_status = lkx_pkg::ST_DATA_DONE;
        in_ready       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.item_load = in_valid;
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!stat.item_mode)
                begin
                    cmd.hash_absorb = 1'b1;
                    if (stat.item_last)
                    begin
                        cmd.hash_finish = 1'b1;
                        ksel_next       = lkx_pkg::KSEL_MIX1;
                        state_next      = S_MUL0;
                    end
                    else
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = lkx_pkg::ST_KEY_BYTE;
                        state_next     = S_DONE;
                    end
                end
                else if (!stat.key_ready)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = lkx_pkg::ST_REJECT;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.w_load_lcg = 1'b1;
                    ksel_next      = lkx_pkg::KSEL_LCG;
                    state_next     = S_MUL0;
                end
            end
            // Low by low partial product.
            S_MUL0:
            begin
                state_next = S_MUL1;
            end
            // Take the low product; high by low partial product.
            S_MUL1:
            begin
                cmd.acc_op   = lkx_pkg::ACC_LOAD;
                cmd.mul_a_hi = 1'b1;
                state_next   = S_MUL2;
            end
            // Add the cross term; low by high partial product.
            S_MUL2:
            begin
                cmd.acc_op   = lkx_pkg::ACC_ADD_HI;
                cmd.mul_b_hi = 1'b1;
                state_next   = S_MUL3;
            end
            // Add the second cross term and pick the follow-up step.
            S_MUL3:
            begin
                cmd.acc_op = lkx_pkg::ACC_ADD_HI;
                case (ksel_reg)
                    lkx_pkg::KSEL_MIX1: state_next = S_MIX;
                    lkx_pkg::KSEL_MIX2: state_next = S_FIN_KEY;
                    default:            state_next = S_FIN_DATA;
                endcase
            end
            S_MIX:
            begin
                cmd.w_load_mix = 1'b1;
                ksel_next      = lkx_pkg::KSEL_MIX2;
                state_next     = S_MUL0;
            end
            S_FIN_KEY:
            begin
                cmd.key_commit = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_status = lkx_pkg::ST_KEY_DONE;
                state_next     = S_DONE;
            end
            S_FIN_DATA:
            begin
                cmd.data_commit = 1'b1;
                cmd.res_load    = 1'b1;
                cmd.res_status  = lkx_pkg::ST_DATA_DONE;
                state_next      = S_DONE;
            end
            // Hand the result over once the output register is free.
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register occupancy.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ksel_reg      <= lkx_pkg::KSEL_LCG;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ksel_reg      <= ksel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: tb/lcg_keystream_xor_cipher_test.sv
// ============================================================================
// lcg_keystream_xor_cipher_test: self-checking bench of the keystream cipher
// A queue-fed driver offers key and data bytes with random idle cycles, a
// clocked monitor predicts each result from its own hash, mixer and LCG
// state and checks every output transaction against the oldest prediction.
// ============================================================================
module lcg_keystream_xor_cipher_test;

    // Hash, mixer and generator constants of the cipher.
    localparam logic [63:0] HASH_START = 64'd5381;
    localparam logic [63:0] STREAM_MUL = 64'd6364136223846793005;
    localparam logic [63:0] STREAM_INC = 64'd1442695040888963407;
    localparam logic [63:0] FOLD_K1    = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FOLD_K2    = 64'hc4ceb9fe1a85ec53;

    // Byte kinds carried by the mode bit.
    localparam logic MODE_KEY  = 1'b0;
    localparam logic MODE_DATA = 1'b1;

    localparam int unsigned WATCHDOG_LIMIT = 1500;
    localparam int unsigned SINK_HOLD_LEN  = 300;
    localparam int unsigned DRAIN_CYCLES   = 20;
    localparam int unsigned REPORT_LIMIT   = 10;

    typedef struct packed {
        logic       mode;
        logic [7:0] byte_in;
        logic       last;
    } cipher_item_t;

    typedef struct packed {
        logic [7:0]       byte_out;
        lkx_pkg::status_t status;
    } cipher_result_t;

    logic clk;
    logic rst_n;

    lkx_in_if  in_ch();
    lkx_out_if out_ch();

    lcg_keystream_xor_cipher u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Predicted cipher state.
    logic [63:0] pred_hash;
    logic [63:0] key_seed;
    logic [63:0] stream_state;
    logic        key_loaded;

    cipher_item_t   pending_items[$];
    cipher_result_t expected_results[$];

    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    int unsigned sink_hold_left;
    int unsigned mismatch_count;
    int unsigned result_count;
    int unsigned quiet_cycles;
    logic        in_fire;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Advances the predicted state by one accepted byte and returns its result.
    function automatic cipher_result_t predict_cipher(input cipher_item_t item);
        cipher_result_t res;
        logic [63:0]    mix;
        res.byte_out = 8'h00;
        if (item.mode == MODE_KEY)
        begin
            pred_hash = ((pred_hash << 5) + pred_hash) ^ {56'd0, item.byte_in};
            if (item.last)
            begin
                mix = pred_hash;
                mix = mix ^ (mix >> 33);
                mix = mix * FOLD_K1;
                mix = mix ^ (mix >> 33);
                mix = mix * FOLD_K2;
                mix = mix ^ (mix >> 33);
                key_seed     = mix;
                stream_state = mix;
                key_loaded   = 1'b1;
                pred_hash    = HASH_START;
                res.status   = lkx_pkg::ST_KEY_DONE;
            end
            else
            begin
                res.status = lkx_pkg::ST_KEY_BYTE;
            end
        end
        else if (!key_loaded)
        begin
            // Data without a completed key leaves every register untouched.
            res.status = lkx_pkg::ST_REJECT;
        end
        else
        begin
            stream_state = stream_state * STREAM_MUL + STREAM_INC;
            res.byte_out = item.byte_in ^ stream_state[23:16];
            res.status   = lkx_pkg::ST_DATA_DONE;
            if (item.last)
            begin
                stream_state = key_seed;
            end
        end
        return res;
    endfunction

    task automatic queue_item(input logic mode, input logic [7:0] byte_in, input logic last);
        cipher_item_t item;
        item.mode    = mode;
        item.byte_in = byte_in;
        item.last    = last;
        pending_items.push_back(item);
    endtask

    // Mostly keys and messages of random length and content, with some noise.
    task automatic queue_random_traffic(input int unsigned item_goal);
        int unsigned queued;
        int unsigned run_len;
        int unsigned pick;
        queued = 0;
        while (queued < item_goal)
        begin
            pick = $urandom_range(19);
            if (pick < 4)
            begin
                run_len = $urandom_range(8, 1);
                for (int i = 1; i <= run_len; i++)
                begin
                    queue_item(MODE_KEY, 8'($urandom_range(255)), i == run_len);
                end
                queued += run_len;
            end
            else if (pick < 18)
            begin
                run_len = $urandom_range(12, 1);
                for (int i = 1; i <= run_len; i++)
                begin
                    // Now and then a key byte lands inside a message.
                    if ($urandom_range(15) == 0)
                    begin
                        queue_item(MODE_KEY, 8'($urandom_range(255)),
                                   $urandom_range(3) == 0);
                        queued++;
                    end
                    queue_item(MODE_DATA, 8'($urandom_range(255)), i == run_len);
                end
                queued += run_len;
            end
            else
            begin
                queue_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                           1'($urandom_range(1)));
                queued++;
            end
        end
    endtask

    task automatic wait_for_drain();
        while (pending_items.size() != 0 || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Input driver: holds an offered transaction until it is accepted.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                void'(pending_items.pop_front());
            end
            if (!in_ch.valid || in_fire)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    in_ch.valid   <= 1'b1;
                    in_ch.mode    <= pending_items[0].mode;
                    in_ch.byte_in <= pending_items[0].byte_in;
                    in_ch.last    <= pending_items[0].last;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Output ready: random stalls, plus one long hold-off when requested.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else if (sink_hold_left != 0)
        begin
            sink_hold_left = sink_hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Monitor: predicts accepted inputs and checks accepted outputs.
    always @(posedge clk)
    begin
        cipher_item_t   item;
        cipher_result_t want;
        cipher_result_t got;
        in_fire <= rst_n && in_ch.valid && in_ch.ready;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.byte_out = out_ch.byte_out;
                got.status   = lkx_pkg::status_t'(out_ch.status);
                result_count++;
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("result %0d: unexpected transaction, byte_out %02h status %0d",
                                 result_count, got.byte_out, got.status);
                    end
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.byte_out !== want.byte_out || got.status !== want.status)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                        begin
                            $display("result %0d: expected %02h/%0d, got %02h/%0d",
                                     result_count, want.byte_out, want.status,
                                     got.byte_out, got.status);
                        end
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                item.mode    = in_ch.mode;
                item.byte_in = in_ch.byte_in;
                item.last    = in_ch.last;
                expected_results.push_back(predict_cipher(item));
            end
            // Watchdog on cycles without any transaction.
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("lcg_keystream_xor_cipher_test: done, errors");
                $finish;
            end
        end
    end

    // Stimulus sequence and end of run.
    initial
    begin
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.mode     = 1'b0;
        in_ch.byte_in  = 8'h00;
        in_ch.last     = 1'b0;
        out_ch.ready   = 1'b0;
        in_fire        = 1'b0;
        sink_hold_left = 0;
        mismatch_count = 0;
        result_count   = 0;
        quiet_cycles   = 0;
        pred_hash      = HASH_START;
        key_seed       = 64'd0;
        stream_state   = 64'd0;
        key_loaded     = 1'b0;
        src_idle_pct   = 23;
        sink_idle_pct  = 59;

        // Data before any key is rejected, even with last set.
        queue_item(MODE_DATA, 8'h00, 1'b0);
        queue_item(MODE_DATA, 8'hFF, 1'b1);
        // One-byte key made of a zero byte.
        queue_item(MODE_KEY, 8'h00, 1'b1);
        queue_item(MODE_DATA, 8'h00, 1'b0);
        queue_item(MODE_DATA, 8'hFF, 1'b0);
        queue_item(MODE_DATA, 8'hA5, 1'b1);
        queue_item(MODE_DATA, 8'h3C, 1'b1);
        // A new key arrives mid-message; the old key stays in use until it completes.
        queue_item(MODE_KEY, 8'hFF, 1'b0);
        queue_item(MODE_DATA, 8'h11, 1'b0);
        queue_item(MODE_KEY, 8'h80, 1'b0);
        queue_item(MODE_DATA, 8'h22, 1'b0);
        queue_item(MODE_KEY, 8'h01, 1'b1);
        queue_item(MODE_DATA, 8'h33, 1'b0);
        queue_item(MODE_DATA, 8'h44, 1'b1);
        // Key of all-ones bytes, then a one-byte message.
        queue_item(MODE_KEY, 8'hFF, 1'b0);
        queue_item(MODE_KEY, 8'hFF, 1'b0);
        queue_item(MODE_KEY, 8'hFF, 1'b1);
        queue_item(MODE_DATA, 8'hFF, 1'b1);
        queue_random_traffic(430);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait_for_drain();
        src_idle_pct  = 59;
        sink_idle_pct = 23;
        queue_random_traffic(150);
        // Long receiver hold-off while the sender keeps offering.
        @(posedge clk);
        sink_hold_left = SINK_HOLD_LEN;
        queue_random_traffic(300);

        wait_for_drain();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        queue_random_traffic(450);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
        begin
            $display("lcg_keystream_xor_cipher_test: done, clean");
        end
        else
        begin
            $display("lcg_keystream_xor_cipher_test: done, errors");
        end
        $finish;
    end

endmodule
